>>> src/xcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared types, codes and constants for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam int unsigned IMAGE_BYTES = 65536;
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned MAX_BLOCKS  = IMAGE_BYTES / BLOCK_BYTES;

  localparam logic [9:0]  BLK_CNT_MAX     = 10'd1023;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd9;
  localparam logic [15:0] TIMEOUT_RST     = 16'd10000;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;

  localparam logic [7:0] IDX_NUMBER     = 8'd0;
  localparam logic [7:0] IDX_COMPLEMENT = 8'd1;
  localparam logic [7:0] IDX_DATA_FIRST = 8'd2;
  localparam logic [7:0] IDX_CHECKSUM   = 8'd130;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [1:0] RPL_NONE = 2'd0;
  localparam logic [1:0] RPL_ACK  = 2'd1;
  localparam logic [1:0] RPL_NAK  = 2'd2;

  localparam logic REG_RETRY_LIMIT = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_BLOCK = 2'd1,
    PH_END   = 2'd2,
    PH_FAIL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  reply;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        finished;
    logic        give_up;
    logic [9:0]  blocks_received;
  } res_t;

endpackage
`default_nettype wire

>>> src/xcr_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XMODEM receiver configuration registers
// APB-style register file holding the retry limit and the timeout.
// ----------------------------------------------------------------------------
module xcr_apb_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output xcr_pkg::cfg_t      cfg
);

  logic [3:0]  retry_limit_r;
  logic [3:0]  retry_limit_nxt;
  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    retry_limit_nxt = retry_limit_r;
    timeout_nxt     = timeout_r;
    prdata          = 32'd0;
    unique case (paddr[2])
      xcr_pkg::REG_RETRY_LIMIT: begin
        prdata = {28'd0, retry_limit_r};
        if (wr_en) begin
          retry_limit_nxt = pwdata[3:0];
        end
      end
      xcr_pkg::REG_TIMEOUT: begin
        prdata = {16'd0, timeout_r};
        if (wr_en) begin
          timeout_nxt = pwdata[15:0];
        end
      end
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= xcr_pkg::RETRY_LIMIT_RST;
      timeout_r     <= xcr_pkg::TIMEOUT_RST;
    end else begin
      retry_limit_r <= retry_limit_nxt;
      timeout_r     <= timeout_nxt;
    end
  end

  assign cfg.retry_limit   = retry_limit_r;
  assign cfg.timeout_ticks = timeout_r;

endmodule
`default_nettype wire

>>> src/xcr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XMODEM receiver protocol engine
// Protocol state, block checking and the result of one transaction.
// ----------------------------------------------------------------------------
module xcr_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire xcr_pkg::item_t item,
  input  wire xcr_pkg::cfg_t  cfg,
  output xcr_pkg::res_t      res
);

  xcr_pkg::phase_t phase_r;
  xcr_pkg::phase_t phase_nxt;
  logic [7:0]  byte_index_r;
  logic [7:0]  byte_index_nxt;
  logic [7:0]  number_r;
  logic [7:0]  number_nxt;
  logic [7:0]  complement_r;
  logic [7:0]  complement_nxt;
  logic [7:0]  sum_r;
  logic [7:0]  sum_nxt;
  logic [9:0]  blocks_r;
  logic [9:0]  blocks_nxt;
  logic [3:0]  retries_r;
  logic [3:0]  retries_nxt;
  logic [15:0] ticks_r;
  logic [15:0] ticks_nxt;

  logic        is_byte;
  logic        is_tick;
  logic        is_start;
  logic        active;
  logic [15:0] tick_inc;
  logic        tick_timeout;
  logic        in_data;
  logic        blk_end;
  logic        blk_ok;
  logic        blk_room;
  logic        retry_evt;
  logic        retry_allowed;
  logic [7:0]  data_off;
  logic [16:0] addr;
  logic        write_en;

  assign is_byte  = (item.action == xcr_pkg::ACT_BYTE);
  assign is_tick  = (item.action == xcr_pkg::ACT_TICK);
  assign is_start = (item.action == xcr_pkg::ACT_START);
  assign active   = (phase_r == xcr_pkg::PH_WAIT) || (phase_r == xcr_pkg::PH_BLOCK);

  assign tick_inc     = ticks_r + 16'd1;
  assign tick_timeout = is_tick && active &&
                        ((tick_inc >= cfg.timeout_ticks) || (tick_inc == 16'd0));

  assign in_data = is_byte && (phase_r == xcr_pkg::PH_BLOCK) &&
                   (byte_index_r >= xcr_pkg::IDX_DATA_FIRST) &&
                   (byte_index_r < xcr_pkg::IDX_CHECKSUM);
  assign blk_end = is_byte && (phase_r == xcr_pkg::PH_BLOCK) &&
                   (byte_index_r >= xcr_pkg::IDX_CHECKSUM);

  assign blk_ok   = (item.rx_byte == sum_r) && (number_r == ~complement_r) &&
                    (number_r == (blocks_r[7:0] + 8'd1));
  assign blk_room = ((32'(blocks_r) + 32'd1) <= xcr_pkg::MAX_BLOCKS) &&
                    (blocks_r < xcr_pkg::BLK_CNT_MAX);

  assign retry_evt     = tick_timeout || (blk_end && !blk_ok);
  assign retry_allowed = (retries_r < cfg.retry_limit);

  assign data_off = byte_index_r - xcr_pkg::IDX_DATA_FIRST;
  assign addr     = {blocks_r, data_off[6:0]};
  assign write_en = in_data && (32'(addr) < xcr_pkg::IMAGE_BYTES);

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    number_nxt     = number_r;
    complement_nxt = complement_r;
    sum_nxt        = sum_r;
    blocks_nxt     = blocks_r;
    retries_nxt    = retries_r;
    ticks_nxt      = ticks_r;
    if (fire) begin
      if (is_start) begin
        phase_nxt      = xcr_pkg::PH_WAIT;
        byte_index_nxt = 8'd0;
        number_nxt     = 8'd0;
        complement_nxt = 8'd0;
        sum_nxt        = 8'd0;
        blocks_nxt     = 10'd0;
        retries_nxt    = 4'd0;
        ticks_nxt      = 16'd0;
      end else begin
        if (is_tick && active) begin
          ticks_nxt = tick_timeout ? 16'd0 : tick_inc;
        end
        if (is_byte) begin
          unique case (phase_r)
            xcr_pkg::PH_WAIT: begin
              if (item.rx_byte == xcr_pkg::CH_SOH) begin
                byte_index_nxt = 8'd0;
                sum_nxt        = 8'd0;
                phase_nxt      = xcr_pkg::PH_BLOCK;
              end else if (item.rx_byte == xcr_pkg::CH_EOT) begin
                phase_nxt = xcr_pkg::PH_END;
              end
            end
            xcr_pkg::PH_BLOCK: begin
              if (byte_index_r == xcr_pkg::IDX_NUMBER) begin
                number_nxt     = item.rx_byte;
                byte_index_nxt = xcr_pkg::IDX_COMPLEMENT;
              end else if (byte_index_r == xcr_pkg::IDX_COMPLEMENT) begin
                complement_nxt = item.rx_byte;
                byte_index_nxt = xcr_pkg::IDX_DATA_FIRST;
              end else if (in_data) begin
                sum_nxt        = sum_r + item.rx_byte;
                byte_index_nxt = byte_index_r + 8'd1;
              end else begin
                byte_index_nxt = 8'd0;
                phase_nxt      = xcr_pkg::PH_WAIT;
                if (blk_ok && blk_room) begin
                  blocks_nxt  = blocks_r + 10'd1;
                  retries_nxt = 4'd0;
                  ticks_nxt   = 16'd0;
                end
              end
            end
            xcr_pkg::PH_END,
            xcr_pkg::PH_FAIL: begin
              phase_nxt = phase_r;
            end
            default: phase_nxt = phase_r;
          endcase
        end
        if (retry_evt) begin
          if (retry_allowed) begin
            retries_nxt = retries_r + 4'd1;
            phase_nxt   = xcr_pkg::PH_WAIT;
          end else begin
            phase_nxt = xcr_pkg::PH_FAIL;
          end
        end
      end
    end
  end

  // Result of the current transaction.
  always_comb begin
    res                 = '0;
    res.blocks_received = blocks_nxt;
    res.write_valid     = write_en;
    res.write_addr      = write_en ? addr[15:0] : 16'd0;
    res.write_data      = write_en ? item.rx_byte : 8'd0;
    res.give_up         = retry_evt && !retry_allowed;
    res.finished        = is_byte && (phase_r == xcr_pkg::PH_WAIT) &&
                          (item.rx_byte == xcr_pkg::CH_EOT);
    if (is_start) begin
      res.reply = xcr_pkg::RPL_NAK;
    end else if (retry_evt && retry_allowed) begin
      res.reply = xcr_pkg::RPL_NAK;
    end else if (res.finished || (blk_end && blk_ok && blk_room)) begin
      res.reply = xcr_pkg::RPL_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= xcr_pkg::PH_WAIT;
      byte_index_r <= 8'd0;
      number_r     <= 8'd0;
      complement_r <= 8'd0;
      sum_r        <= 8'd0;
      blocks_r     <= 10'd0;
      retries_r    <= 4'd0;
      ticks_r      <= 16'd0;
    end else begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      number_r     <= number_nxt;
      complement_r <= complement_nxt;
      sum_r        <= sum_nxt;
      blocks_r     <= blocks_nxt;
      retries_r    <= retries_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/xmodem_checksum_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receiver for 128-byte XMODEM blocks with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Each input transaction (a received byte, a timer tick or a start command)
// yields exactly one result transaction. The block takes one transaction per
// cycle while the result is not stalled. A taken input is held in the input
// register until it fires, when the protocol state is updated in a single step
// and the result register is loaded. While the result is stalled, a waiting
// input holds its register and further input is stalled. The user must write
// configuration through the APB port only while no transaction is in flight;
// the block itself does not enforce this.
module xmodem_checksum_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  out_reply,
  output logic             out_write_valid,
  output logic      [15:0] out_write_addr,
  output logic      [7:0]  out_write_data,
  output logic             out_finished,
  output logic             out_give_up,
  output logic      [9:0]  out_blocks_received,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  xcr_pkg::cfg_t  cfg;
  xcr_pkg::item_t item_r;
  xcr_pkg::item_t item_nxt;
  logic           item_valid_r;
  logic           item_valid_nxt;
  xcr_pkg::res_t  res;
  xcr_pkg::res_t  res_r;
  xcr_pkg::res_t  res_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           advance;
  logic           fire;
  logic           in_take;

  xcr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  xcr_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_nxt       = item_r;
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_nxt.action  = in_action;
      item_nxt.rx_byte = in_rx_byte;
      item_valid_nxt   = 1'b1;
    end else if (fire) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      res_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_reply           = res_r.reply;
  assign out_write_valid     = res_r.write_valid;
  assign out_write_addr      = res_r.write_addr;
  assign out_write_data      = res_r.write_data;
  assign out_finished        = res_r.finished;
  assign out_give_up         = res_r.give_up;
  assign out_blocks_received = res_r.blocks_received;

endmodule
`default_nettype wire

>>> src/xcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XMODEM receiver port checker
// Checks on the result channel of the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
module xcr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_reply,
  input wire logic        out_write_valid,
  input wire logic [15:0] out_write_addr,
  input wire logic [7:0]  out_write_data,
  input wire logic        out_finished,
  input wire logic        out_give_up,
  input wire logic [9:0]  out_blocks_received
);

  // A stalled result transaction holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply) &&
      $stable(out_write_valid) && $stable(out_write_addr) &&
      $stable(out_write_data) && $stable(out_blocks_received))
    else $error("stalled result transaction changed");

  // A data byte write never carries a reply or an end of transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_reply == xcr_pkg::RPL_NONE &&
      !out_finished && !out_give_up)
    else $error("data write combined with a reply");

  // The end of a transfer is acknowledged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_reply == xcr_pkg::RPL_ACK && !out_give_up)
    else $error("finished without ACK");

  // Giving up sends no reply and writes nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_give_up |-> out_reply == xcr_pkg::RPL_NONE &&
      !out_write_valid && out_write_addr == 16'd0 && out_write_data == 8'd0)
    else $error("give up combined with a reply or write");

endmodule

bind xmodem_checksum_receiver_top xcr_checker u_xcr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_reply           (out_reply),
  .out_write_valid     (out_write_valid),
  .out_write_addr      (out_write_addr),
  .out_write_data      (out_write_data),
  .out_finished        (out_finished),
  .out_give_up         (out_give_up),
  .out_blocks_received (out_blocks_received)
);
`default_nettype wire
